// ===== hdl/crt_pkg.sv =====
package crt_pkg;

    localparam int BUFFER_WORDS_DEF = 128;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH      = 2;

    // Item kinds and register selects on the input side.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] SEL_AUX    = 2'd0;
    localparam logic [1:0] SEL_CTL    = 2'd1;
    localparam logic [1:0] SEL_CMD    = 2'd2;
    localparam logic [1:0] SEL_DATA   = 2'd3;

    // Operations handed from the front part to the back part.
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_ERR     = 4'd1;
    localparam logic [3:0] OP_BAUD_WR = 4'd2;
    localparam logic [3:0] OP_AUX1_WR = 4'd3;
    localparam logic [3:0] OP_CTL3_WR = 4'd4;
    localparam logic [3:0] OP_CMD_WR  = 4'd5;
    localparam logic [3:0] OP_BAUD_RD = 4'd6;
    localparam logic [3:0] OP_AUX1_RD = 4'd7;
    localparam logic [3:0] OP_ZERO_RD = 4'd8;
    localparam logic [3:0] OP_STAT_RD = 4'd9;
    localparam logic [3:0] OP_CTL3_RD = 4'd10;
    localparam logic [3:0] OP_CMD_RD  = 4'd11;
    localparam logic [3:0] OP_DATA_RD = 4'd12;
    localparam logic [3:0] OP_FILL    = 4'd13;

    localparam logic [7:0]  CMD_READ    = 8'hB7;
    localparam logic [7:0]  CMD_CHIP_ID = 8'hB8;
    localparam logic [31:0] CHIP_ID     = 32'h0000_1FC2;
    localparam logic [31:0] PROT_LIMIT  = 32'h0000_7FFF;
    localparam logic [31:0] PROT_BASE   = 32'h0000_8000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [12:0] BIG_BLOCK   = 13'h0080;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  off;
        logic [7:0]  wdata;
        logic [31:0] fill;
    } t_item;

endpackage

// ===== hdl/crt_front.sv =====
module crt_front (
    input  logic          i_valid,
    input  logic [1:0]    i_kind,
    input  logic [1:0]    i_sel,
    input  logic [2:0]    i_off,
    input  logic [7:0]    i_wdata,
    input  logic [31:0]   i_fill,
    input  logic          i_q_ready,
    output logic          o_ready,
    output logic          o_push,
    output crt_pkg::t_item o_item
);

    logic [3:0] op;

    // Decode the register map into one operation per item.
    always_comb begin
        op = crt_pkg::OP_ERR;
        case (i_kind)
            crt_pkg::KIND_WRITE: begin
                case (i_sel)
                    crt_pkg::SEL_AUX: begin
                        if (i_off == 3'd0) op = crt_pkg::OP_BAUD_WR;
                        else if (i_off == 3'd1) op = crt_pkg::OP_AUX1_WR;
                        else op = crt_pkg::OP_ERR;
                    end
                    crt_pkg::SEL_CTL: begin
                        if (i_off == 3'd3) op = crt_pkg::OP_CTL3_WR;
                        else if (i_off > 3'd3) op = crt_pkg::OP_ERR;
                        else op = crt_pkg::OP_NOP;
                    end
                    crt_pkg::SEL_CMD: op = crt_pkg::OP_CMD_WR;
                    default: op = crt_pkg::OP_NOP;
                endcase
            end
            crt_pkg::KIND_READ: begin
                case (i_sel)
                    crt_pkg::SEL_AUX: begin
                        if (i_off == 3'd0) op = crt_pkg::OP_BAUD_RD;
                        else if (i_off == 3'd1) op = crt_pkg::OP_AUX1_RD;
                        else op = crt_pkg::OP_ERR;
                    end
                    crt_pkg::SEL_CTL: begin
                        if (i_off == 3'd2) op = crt_pkg::OP_STAT_RD;
                        else if (i_off == 3'd3) op = crt_pkg::OP_CTL3_RD;
                        else if (i_off > 3'd3) op = crt_pkg::OP_ERR;
                        else op = crt_pkg::OP_ZERO_RD;
                    end
                    crt_pkg::SEL_CMD: op = crt_pkg::OP_CMD_RD;
                    default: op = crt_pkg::OP_DATA_RD;
                endcase
            end
            crt_pkg::KIND_FILL: op = crt_pkg::OP_FILL;
            default: op = crt_pkg::OP_ERR;
        endcase
    end

    assign o_ready      = i_q_ready;
    assign o_push       = i_valid && i_q_ready;
    assign o_item.op    = op;
    assign o_item.off   = i_off;
    assign o_item.wdata = i_wdata;
    assign o_item.fill  = i_fill;

endmodule

// ===== hdl/crt_queue.sv =====
module crt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crt_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_ready,
    output logic           o_valid,
    output crt_pkg::t_item o_item
);

    localparam int PW = $clog2(crt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(crt_pkg::QUEUE_DEPTH + 1);

    crt_pkg::t_item r_slot [crt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_ready = r_cnt != CW'(crt_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(crt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(crt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== hdl/crt_back.sv =====
module crt_back #(
    parameter int BUFFER_WORDS = crt_pkg::BUFFER_WORDS_DEF,
    parameter int SECTOR_BYTES = crt_pkg::SECTOR_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_item_valid,
    input  crt_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [31:0]    o_read_data,
    output logic           o_irq,
    output logic           o_fetch_req,
    output logic [31:0]    o_fetch_addr,
    output logic           o_err
);

    localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int VW = $clog2(BUFFER_WORDS + 1);
    localparam logic [31:0] SMASK = 32'(SECTOR_BYTES - 1);

    logic [31:0] r_mask;
    logic [7:0]  r_cmd [8];
    logic [2:0]  r_bsc;
    logic [1:0]  r_baud;
    logic        r_spi, r_irq_en, r_slot;
    logic [12:0] r_idx, r_wc;
    logic [VW-1:0] r_valid, r_fp;
    logic [AW-1:0] r_rp;
    logic [31:0] r_base;
    logic        r_filling, r_id_mode;
    logic [31:0] r_buf [BUFFER_WORDS];
    logic [31:0] r_mem_q;

    logic [2:0]  n_bsc;
    logic [1:0]  n_baud;
    logic        n_spi, n_irq_en, n_slot;
    logic [12:0] n_idx, n_wc;
    logic [VW-1:0] n_valid, n_fp;
    logic [AW-1:0] n_rp;
    logic [31:0] n_base;
    logic        n_filling, n_id_mode;

    logic        r_out_valid, r_use_mem, r_irq, r_freq, r_err;
    logic [31:0] r_rd, r_faddr;
    logic        n_use_mem, n_irq, n_freq, n_err;
    logic [31:0] n_rd, n_faddr;

    logic        adv, take, busy, buf_we, cmd_we;
    logic [12:0] wc_new, idx_inc;
    logic [31:0] addr, fp_off;
    logic [VW-1:0] fp_inc;

    assign adv   = !r_out_valid || i_out_ready;
    assign take  = adv && i_item_valid;
    assign o_pop = take;
    assign busy  = r_wc != '0;

    always_comb begin
        n_bsc = r_bsc; n_baud = r_baud; n_spi = r_spi; n_irq_en = r_irq_en;
        n_slot = r_slot; n_idx = r_idx; n_wc = r_wc; n_valid = r_valid;
        n_fp = r_fp; n_rp = r_rp; n_base = r_base; n_filling = r_filling;
        n_id_mode = r_id_mode;
        n_rd = '0; n_use_mem = 1'b0; n_irq = 1'b0; n_freq = 1'b0;
        n_faddr = '0; n_err = 1'b0;
        buf_we = 1'b0; cmd_we = 1'b0;
        wc_new = '0; addr = '0; idx_inc = r_idx + 13'd1;
        fp_inc = r_fp + 1'b1;
        fp_off = 32'(fp_inc) << 2;
        case (i_item.op)
            crt_pkg::OP_ERR:     n_err = 1'b1;
            crt_pkg::OP_BAUD_WR: n_baud = i_item.wdata[1:0];
            crt_pkg::OP_AUX1_WR: begin
                n_spi = i_item.wdata[5]; n_irq_en = i_item.wdata[6];
                n_slot = i_item.wdata[7];
            end
            crt_pkg::OP_CMD_WR:  cmd_we = 1'b1;
            crt_pkg::OP_CTL3_WR: begin
                n_bsc = i_item.wdata[2:0];
                if (i_item.wdata[7]) begin
                    if (busy) n_err = 1'b1;
                    if (i_item.wdata[2:0] == 3'd0) wc_new = '0;
                    else if (i_item.wdata[2:0] == 3'd7) wc_new = 13'd1;
                    else wc_new = 13'h40 << i_item.wdata[2:0];
                    n_wc = wc_new; n_idx = '0; n_rp = '0; n_fp = '0;
                    n_filling = 1'b0; n_valid = '0;
                    if (r_cmd[0] == crt_pkg::CMD_READ) begin
                        n_id_mode = 1'b0;
                        addr = {r_cmd[1], r_cmd[2], r_cmd[3], r_cmd[4]} & r_mask;
                        if (addr <= crt_pkg::PROT_LIMIT)
                            addr = crt_pkg::PROT_BASE | {23'd0, addr[8:0]};
                        if (wc_new > crt_pkg::BIG_BLOCK || addr[8:0] != '0) n_err = 1'b1;
                        n_valid = (wc_new < 13'(BUFFER_WORDS)) ? VW'(wc_new)
                                                                : VW'(BUFFER_WORDS);
                        if (n_valid != '0) begin
                            n_base = addr; n_filling = 1'b1;
                            n_freq = 1'b1; n_faddr = addr;
                        end
                    end else if (r_cmd[0] == crt_pkg::CMD_CHIP_ID) begin
                        n_id_mode = 1'b1; n_valid = VW'(1);
                        n_irq = r_irq_en;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
            crt_pkg::OP_BAUD_RD: n_rd = {30'd0, r_baud};
            crt_pkg::OP_AUX1_RD: n_rd = {24'd0, r_slot, r_irq_en, r_spi, 5'd0};
            crt_pkg::OP_ZERO_RD: n_rd = '0;
            crt_pkg::OP_STAT_RD: n_rd = {24'd0, busy && !r_filling, 7'd0};
            crt_pkg::OP_CTL3_RD: n_rd = {24'd0, busy, 4'd0, r_bsc};
            crt_pkg::OP_CMD_RD:  n_rd = {24'd0, r_cmd[i_item.off]};
            crt_pkg::OP_DATA_RD: begin
                n_rd = crt_pkg::ALL_ONES;
                if (!busy) begin
                    n_err = 1'b1;
                end else begin
                    if (r_filling) n_err = 1'b1;
                    else if (r_valid != '0) begin
                        if (r_id_mode) n_rd = crt_pkg::CHIP_ID;
                        else n_use_mem = 1'b1;
                    end
                    if (r_valid != '0)
                        n_rp = (VW'(r_rp) + 1'b1 == r_valid) ? '0 : r_rp + 1'b1;
                    if (idx_inc == r_wc) begin
                        n_idx = '0; n_wc = '0;
                    end else begin
                        n_idx = idx_inc; n_irq = r_irq_en;
                    end
                end
            end
            crt_pkg::OP_FILL: begin
                if (r_filling) begin
                    buf_we = 1'b1;
                    n_fp = fp_inc;
                    if (fp_inc >= r_valid) begin
                        n_filling = 1'b0;
                        n_irq = r_irq_en && busy;
                    end else begin
                        n_freq = 1'b1;
                        n_faddr = (r_base & ~SMASK) | ((r_base + fp_off) & SMASK);
                    end
                end
            end
            default: n_rd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && buf_we) r_buf[r_fp[AW-1:0]] <= i_item.fill;
        if (take) r_mem_q <= r_buf[r_rp];
        if (take) begin
            r_rd <= n_rd; r_use_mem <= n_use_mem; r_irq <= n_irq;
            r_freq <= n_freq; r_faddr <= n_faddr; r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= crt_pkg::ALL_ONES;
            for (int k = 0; k < 8; k++) r_cmd[k] <= '0;
            r_bsc <= '0; r_baud <= '0; r_spi <= 1'b0; r_irq_en <= 1'b0;
            r_slot <= 1'b0; r_idx <= '0; r_wc <= '0; r_valid <= '0;
            r_fp <= '0; r_rp <= '0; r_base <= '0; r_filling <= 1'b0;
            r_id_mode <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_mask <= i_cfg_data;
            if (adv) r_out_valid <= i_item_valid;
            if (take) begin
                if (cmd_we) r_cmd[i_item.off] <= i_item.wdata;
                r_bsc <= n_bsc; r_baud <= n_baud; r_spi <= n_spi;
                r_irq_en <= n_irq_en; r_slot <= n_slot; r_idx <= n_idx;
                r_wc <= n_wc; r_valid <= n_valid; r_fp <= n_fp; r_rp <= n_rp;
                r_base <= n_base; r_filling <= n_filling; r_id_mode <= n_id_mode;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_use_mem ? r_mem_q : r_rd;
    assign o_irq        = r_irq;
    assign o_fetch_req  = r_freq;
    assign o_fetch_addr = r_faddr;
    assign o_err        = r_err;

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> (r_fp < r_valid))
        else $error("fill pointer past buffered word count");
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wc == '0) |-> (r_idx == '0))
        else $error("word index nonzero while idle");
    a_read_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid != '0) |-> (VW'(r_rp) < r_valid))
        else $error("read pointer outside buffered words");
    a_fetch_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_freq) |-> (r_faddr == '0))
        else $error("fetch address without fetch request");

endmodule

// ===== hdl/cart_rom_transfer_controller.sv =====
// Channel   Direction  tdata (low bit up)                      tuser (low bit up)
// s_axis    in         byte_offset[2:0] write_data[10:3]        kind[1:0] reg_select[3:2]
//                      fill_word[42:11], zero pad to 48
// m_axis    out        read_data[31:0] fetch_address[63:32]     irq_pulse[0]
//                                                               fetch_request[1] error_flag[2]
// cfg       in         i_cfg_wdata = rom_address_mask, written when i_cfg_we is high
//
// One item is accepted per clock when the two-entry queue has room; the queue entry is
// written at the accepting edge, and the execution stage, whose register also holds the
// buffer read data, registers the result when it takes the entry from the queue.
// The buffer RAM is read for every item and written for each fill item while filling.
// Reset is synchronous and active low; the word buffer is not cleared.
// An output stall holds the result and stops the execution stage; the queue
// absorbs up to two further items before s_axis_tready drops.
module cart_rom_transfer_controller #(
    parameter int BUFFER_WORDS = crt_pkg::BUFFER_WORDS_DEF,
    parameter int SECTOR_BYTES = crt_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // byte_offset, write_data, fill_word, pad
    input  logic [3:0]  s_axis_tuser,   // kind, reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // read_data, fetch_address
    output logic [2:0]  m_axis_tuser    // irq_pulse, fetch_request, error_flag
);

    crt_pkg::t_item front_item, queue_item;
    logic push, q_ready, q_valid, pop;
    logic [31:0] rd, faddr;
    logic irq, freq, err;

    // The front part decodes each item into an operation for the back part.
    crt_front u_front (
        .i_valid   (s_axis_tvalid),
        .i_kind    (s_axis_tuser[1:0]),
        .i_sel     (s_axis_tuser[3:2]),
        .i_off     (s_axis_tdata[2:0]),
        .i_wdata   (s_axis_tdata[10:3]),
        .i_fill    (s_axis_tdata[42:11]),
        .i_q_ready (q_ready),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_item    (front_item)
    );

    crt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (queue_item)
    );

    // The back part owns all transfer state, the word buffer and the result register.
    crt_back #(
        .BUFFER_WORDS (BUFFER_WORDS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_wdata),
        .i_item_valid (q_valid),
        .i_item       (queue_item),
        .o_pop        (pop),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_read_data  (rd),
        .o_irq        (irq),
        .o_fetch_req  (freq),
        .o_fetch_addr (faddr),
        .o_err        (err)
    );

    assign m_axis_tdata = {faddr, rd};
    assign m_axis_tuser = {err, freq, irq};

endmodule
